// ----- hdl/clra_pkg.sv -----
// ----------------------------------------------------------------------------
// clra_pkg
// Shared codes, widths and controller/datapath interface types for the
// continued line record assembler.
// ----------------------------------------------------------------------------
package clra_pkg;

  // default sizes
  localparam int unsigned RECORD_DEPTH_DEF = 1024;
  localparam int unsigned LINE_MAX_DEF     = 162;
  localparam int unsigned FIELD_MAX_DEF    = 64;

  // fixed field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FPOS_W   = 11;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TYPE_W   = 8;
  localparam int unsigned RLEN_W   = 11;

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_BYTE  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_EOL   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_EOI   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_FIELD = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_REC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // record status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVF  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EOI  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LONG = 3'd5;

  // characters
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
  localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [2*BYTE_W-1:0] PREFIX_CONT = 16'h3030;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic rd;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic field_go;
    logic field_last;
  } sts_t;

endpackage

// ----- hdl/clra_ctrl.sv -----
// ----------------------------------------------------------------------------
// clra_ctrl
// Sequencer: input handshake and the field read loop that streams one
// character per cycle out of the record store while the output is free.
// ----------------------------------------------------------------------------
module clra_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [clra_pkg::OPCODE_W-1:0]  opcode_i,
  output logic                           in_ready_o,
  input  clra_pkg::sts_t                 sts_i,
  output clra_pkg::cmd_t                 cmd_o
);
  import clra_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    in_ready_o  = (state_q == S_IDLE) && sts_i.out_free;
    cmd_o.take  = in_valid_i && in_ready_o;
    cmd_o.rd    = 1'b0;
    cmd_o.emit  = 1'b0;
    state_d     = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.take && (opcode_i == OP_FIELD) && sts_i.field_go) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_STREAM;
      end
      S_STREAM: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.field_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/clra_dp.sv -----
// ----------------------------------------------------------------------------
// clra_dp
// Datapath: line tracking, record store, end of line checks, record type
// decode, field read pointer and the output register.
// ----------------------------------------------------------------------------
module clra_dp #(
  parameter int unsigned RECORD_DEPTH = clra_pkg::RECORD_DEPTH_DEF,
  parameter int unsigned LINE_MAX     = clra_pkg::LINE_MAX_DEF,
  parameter int unsigned FIELD_MAX    = clra_pkg::FIELD_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [clra_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [clra_pkg::BYTE_W-1:0]         line_byte_i,
  input  logic [clra_pkg::FPOS_W-1:0]         field_start_i,
  input  logic [clra_pkg::FPOS_W-1:0]         field_end_i,
  input  logic                                out_ready_i,
  input  clra_pkg::cmd_t                      cmd_i,
  output clra_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  output logic [clra_pkg::KIND_W-1:0]         kind_o,
  output logic [clra_pkg::STATUS_W-1:0]       status_o,
  output logic signed [clra_pkg::TYPE_W-1:0]  record_type_o,
  output logic [clra_pkg::RLEN_W-1:0]         record_length_o,
  output logic [clra_pkg::BYTE_W-1:0]         field_char_o,
  output logic                                last_o
);
  import clra_pkg::*;

  localparam int unsigned ADDR_W = $clog2(RECORD_DEPTH);
  localparam int unsigned LEN_W  = $clog2(RECORD_DEPTH + 1);
  localparam int unsigned SUM_W  = LEN_W + 1;
  localparam int unsigned POS_W  = $clog2(LINE_MAX + 2);
  localparam int unsigned CNT_W  = $clog2(FIELD_MAX + 1);
  localparam int unsigned CMP_W  = (LEN_W > FPOS_W) ? LEN_W : FPOS_W;
  localparam int unsigned SIZE_W = FPOS_W + 1;
  localparam int unsigned PTR_W  = FPOS_W + 1;

  // atoi of the first two record characters
  function automatic logic [TYPE_W-1:0] rec_type(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
    logic               bd, ad, aws;
    logic [BYTE_W-1:0]  av, bv;
    bd  = (b >= CH_ZERO) && (b <= CH_NINE);
    ad  = (a >= CH_ZERO) && (a <= CH_NINE);
    aws = (a == CH_SPACE) || ((a >= CH_TAB) && (a <= CH_CR));
    av  = a - CH_ZERO;
    bv  = b - CH_ZERO;
    rec_type = '0;
    if (aws || (a == CH_PLUS)) begin
      rec_type = bd ? bv : '0;
    end else if (a == CH_MINUS) begin
      rec_type = bd ? (~bv + 8'd1) : '0;
    end else if (ad) begin
      rec_type = bd ? ((av << 3) + (av << 1) + bv) : av;
    end
  endfunction

  // record store
  logic [BYTE_W-1:0] mem [RECORD_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // record and line state
  logic [LEN_W-1:0]    len_q, len_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    trim_q, trim_d;
  logic [2*BYTE_W-1:0] prefix_q, prefix_d;
  logic [BYTE_W-1:0]   endm_q, endm_d;
  logic [BYTE_W-1:0]   flag_q, flag_d;
  logic                closed_q, closed_d;
  logic [BYTE_W-1:0]   rec0_q, rec1_q;

  // field read state
  logic              beyond_q;
  logic [CNT_W-1:0]  n_q, cnt_q;
  logic [PTR_W-1:0]  rd_ptr_q;

  // output register
  logic                 out_valid_q;
  logic [KIND_W-1:0]    kind_q;
  logic [STATUS_W-1:0]  status_q;
  logic [TYPE_W-1:0]    type_q;
  logic [RLEN_W-1:0]    length_q;
  logic [BYTE_W-1:0]    char_q;
  logic                 last_q;

  // line state as seen after a closed record reopens
  logic [LEN_W-1:0]    eff_len;
  logic [POS_W-1:0]    eff_pos, eff_trim;
  logic [2*BYTE_W-1:0] eff_prefix;
  logic [BYTE_W-1:0]   eff_endm, eff_flag;

  logic              in_line;
  logic [1:0]        skip;
  logic [SUM_W-1:0]  wr_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_idx, rd_idx;
  logic              rd_en;

  logic                eol_fin;
  logic [STATUS_W-1:0] eol_status;
  logic [SUM_W-1:0]    total;
  logic [POS_W-1:0]    add;

  logic                rec_load, empty_load;
  logic [STATUS_W-1:0] fin_status;
  logic [LEN_W-1:0]    fin_len;

  logic              fld_beyond;
  logic [SIZE_W-1:0] fld_size;
  logic [CNT_W-1:0]  fld_n;

  // effective state: a closed record reads as empty with a fresh line
  always_comb begin
    eff_len    = closed_q ? '0 : len_q;
    eff_pos    = closed_q ? '0 : pos_q;
    eff_trim   = closed_q ? '0 : trim_q;
    eff_prefix = closed_q ? '0 : prefix_q;
    eff_endm   = closed_q ? '0 : endm_q;
    eff_flag   = closed_q ? '0 : flag_q;
  end

  // store write for a line byte
  always_comb begin
    in_line = eff_pos < POS_W'(LINE_MAX);
    skip    = (eff_len == '0) ? 2'd0 : 2'd2;
    wr_addr = SUM_W'(eff_len) + SUM_W'(eff_pos) - SUM_W'(skip);
    wr_en   = cmd_i.take && (opcode_i == OP_BYTE) && in_line
              && (eff_pos >= POS_W'(skip)) && (wr_addr < SUM_W'(RECORD_DEPTH));
    wr_idx  = ADDR_W'(wr_addr);
    rd_idx  = ADDR_W'(rd_ptr_q);
    rd_en   = cmd_i.rd && !beyond_q;
  end

  // end of line checks
  always_comb begin
    eol_fin    = 1'b1;
    eol_status = ST_OK;
    add        = '0;
    if (eff_pos > POS_W'(LINE_MAX)) begin
      eol_status = ST_LONG;
    end else if ((eff_trim < POS_W'(2)) || (eff_endm != CH_PCT)) begin
      eol_status = ST_MISS;
    end else if ((eff_len != '0)
                 && ((eff_prefix != PREFIX_CONT) || (eff_trim < POS_W'(4)))) begin
      eol_status = ST_BADC;
    end else begin
      add = (eff_len == '0) ? (eff_trim - POS_W'(2)) : (eff_trim - POS_W'(4));
    end
    total = SUM_W'(eff_len) + SUM_W'(add);
    if (eol_status == ST_OK) begin
      if (total > SUM_W'(RECORD_DEPTH)) begin
        eol_status = ST_OVF;
      end else if (eff_flag == CH_ONE) begin
        eol_fin = 1'b0;
      end
    end
  end

  // field request decode
  always_comb begin
    fld_beyond = (field_start_i == '0) || (CMP_W'(field_end_i) > CMP_W'(len_q));
    fld_size   = SIZE_W'(field_end_i) - SIZE_W'(field_start_i) + SIZE_W'(1);
    fld_n      = (fld_size < SIZE_W'(FIELD_MAX)) ? CNT_W'(fld_size) : CNT_W'(FIELD_MAX);
    sts_o.field_go   = (len_q != '0) && (field_end_i >= field_start_i);
    sts_o.field_last = ((cnt_q + 1'b1) == n_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // next record and line state
  always_comb begin
    len_d      = len_q;
    pos_d      = pos_q;
    trim_d     = trim_q;
    prefix_d   = prefix_q;
    endm_d     = endm_q;
    flag_d     = flag_q;
    closed_d   = closed_q;
    rec_load   = 1'b0;
    empty_load = 1'b0;
    fin_status = ST_OK;
    fin_len    = '0;
    if (cmd_i.take) begin
      unique case (opcode_i)
        OP_BYTE: begin
          closed_d = 1'b0;
          len_d    = eff_len;
          trim_d   = eff_trim;
          prefix_d = eff_prefix;
          endm_d   = eff_endm;
          flag_d   = eff_flag;
          if (in_line) begin
            if (eff_pos == '0) begin
              prefix_d = {line_byte_i, 8'h00};
            end else if (eff_pos == POS_W'(1)) begin
              prefix_d = {eff_prefix[2*BYTE_W-1:BYTE_W], line_byte_i};
            end
            if (line_byte_i != CH_SPACE) begin
              flag_d = (eff_trim == eff_pos) ? eff_endm : CH_SPACE;
              endm_d = line_byte_i;
              trim_d = eff_pos + 1'b1;
            end
          end
          pos_d = (eff_pos <= POS_W'(LINE_MAX)) ? (eff_pos + 1'b1) : eff_pos;
        end
        OP_EOL: begin
          pos_d    = '0;
          trim_d   = '0;
          prefix_d = '0;
          endm_d   = '0;
          flag_d   = '0;
          if (eol_fin) begin
            closed_d   = 1'b1;
            rec_load   = 1'b1;
            fin_status = eol_status;
            fin_len    = (eol_status == ST_OK) ? LEN_W'(total) : '0;
            len_d      = fin_len;
          end else begin
            closed_d = 1'b0;
            len_d    = LEN_W'(total);
          end
        end
        OP_EOI: begin
          if (!closed_q) begin
            closed_d   = 1'b1;
            rec_load   = 1'b1;
            fin_status = ST_EOI;
            len_d      = '0;
            pos_d      = '0;
            trim_d     = '0;
            prefix_d   = '0;
            endm_d     = '0;
            flag_d     = '0;
          end
        end
        OP_FIELD: begin
          empty_load = !sts_o.field_go;
        end
        default: begin
        end
      endcase
    end
  end

  // record and line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      pos_q    <= '0;
      trim_q   <= '0;
      prefix_q <= '0;
      endm_q   <= '0;
      flag_q   <= '0;
      closed_q <= 1'b1;
    end else begin
      len_q    <= len_d;
      pos_q    <= pos_d;
      trim_q   <= trim_d;
      prefix_q <= prefix_d;
      endm_q   <= endm_d;
      flag_q   <= flag_d;
      closed_q <= closed_d;
    end
  end

  // record store with registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= line_byte_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_idx];
    end
  end

  // copies of the first two record characters for the type decode
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr == SUM_W'(0))) begin
      rec0_q <= line_byte_i;
    end
    if (wr_en && (wr_addr == SUM_W'(1))) begin
      rec1_q <= line_byte_i;
    end
  end

  // field read pointer and character count
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (opcode_i == OP_FIELD) && sts_o.field_go) begin
      beyond_q <= fld_beyond;
      n_q      <= fld_n;
      cnt_q    <= '0;
      rd_ptr_q <= PTR_W'(field_start_i) - PTR_W'(1);
    end else begin
      if (cmd_i.rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (cmd_i.emit) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_load || empty_load || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (rec_load) begin
      kind_q   <= KIND_REC;
      status_q <= fin_status;
      type_q   <= (fin_len >= LEN_W'(2)) ? rec_type(rec0_q, rec1_q) : '0;
      length_q <= RLEN_W'(fin_len);
      char_q   <= '0;
      last_q   <= 1'b1;
    end else if (empty_load) begin
      kind_q   <= KIND_EMPTY;
      status_q <= ST_OK;
      type_q   <= '0;
      length_q <= '0;
      char_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit) begin
      kind_q   <= KIND_CHAR;
      status_q <= ST_OK;
      type_q   <= '0;
      length_q <= '0;
      char_q   <= beyond_q ? CH_SPACE : rdata_q;
      last_q   <= sts_o.field_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign status_o        = status_q;
  assign record_type_o   = type_q;
  assign record_length_o = length_q;
  assign field_char_o    = char_q;
  assign last_o          = last_q;

endmodule

// ----- hdl/continued_line_record_assembler.sv -----
// ----------------------------------------------------------------------------
// continued_line_record_assembler
// Assembles one record from continued text lines received byte by byte and
// serves field reads out of the record store.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  input   | in_valid_i, in_ready_o | opcode_i, line_byte_i, field_start_i,
//          |                        | field_end_i
//  output  | out_valid_o,out_ready_i| kind_o, status_o, record_type_o,
//          |                        | record_length_o, field_char_o, last_o
//
//  line byte, end of line, end of input and empty field reads are handled in the
//  accepting cycle; a field read of n characters takes the accepting cycle, the
//  read state that primes the registered read port of the record store, then
//  one character a cycle while the output register is free
//  reset is asynchronous; the record store is not cleared and needs no sweep
//  input is held off while the output register holds a result not taken in
//  that cycle, and for the whole of a field read
// ----------------------------------------------------------------------------
module continued_line_record_assembler #(
  parameter int unsigned RECORD_DEPTH = clra_pkg::RECORD_DEPTH_DEF,
  parameter int unsigned LINE_MAX     = clra_pkg::LINE_MAX_DEF,
  parameter int unsigned FIELD_MAX    = clra_pkg::FIELD_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [clra_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [clra_pkg::BYTE_W-1:0]         line_byte_i,
  input  logic [clra_pkg::FPOS_W-1:0]         field_start_i,
  input  logic [clra_pkg::FPOS_W-1:0]         field_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [clra_pkg::KIND_W-1:0]         kind_o,
  output logic [clra_pkg::STATUS_W-1:0]       status_o,
  output logic signed [clra_pkg::TYPE_W-1:0]  record_type_o,
  output logic [clra_pkg::RLEN_W-1:0]         record_length_o,
  output logic [clra_pkg::BYTE_W-1:0]         field_char_o,
  output logic                                last_o
);
  import clra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  clra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  clra_dp #(
    .RECORD_DEPTH (RECORD_DEPTH),
    .LINE_MAX     (LINE_MAX),
    .FIELD_MAX    (FIELD_MAX)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (opcode_i),
    .line_byte_i     (line_byte_i),
    .field_start_i   (field_start_i),
    .field_end_i     (field_end_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .record_type_o   (record_type_o),
    .record_length_o (record_length_o),
    .field_char_o    (field_char_o),
    .last_o          (last_o)
  );

endmodule

// ----- hdl/clra_checker.sv -----
// ----------------------------------------------------------------------------
// clra_checker
// Port level checks for the continued line record assembler, bound to the
// top level.
// ----------------------------------------------------------------------------
module clra_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [clra_pkg::KIND_W-1:0]         kind_o,
  input logic [clra_pkg::STATUS_W-1:0]       status_o,
  input logic signed [clra_pkg::TYPE_W-1:0]  record_type_o,
  input logic [clra_pkg::RLEN_W-1:0]         record_length_o,
  input logic [clra_pkg::BYTE_W-1:0]         field_char_o,
  input logic                                last_o
);
  import clra_pkg::*;

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(field_char_o) && $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // a record report is always the only result of its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_REC) |-> last_o)
    else $error("record report without last");

  // field results carry no record information
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_REC) |->
      (status_o == ST_OK) && (record_type_o == '0) && (record_length_o == '0))
    else $error("field result with record fields set");

  // an empty field result is a single zero transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_EMPTY) |-> last_o && (field_char_o == '0))
    else $error("bad empty field result");

  // a failed record is reported empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_REC) && (status_o != ST_OK) |->
      (record_length_o == '0) && (record_type_o == '0))
    else $error("failed record reported with contents");

endmodule

bind continued_line_record_assembler clra_checker u_clra_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives text lines, end-of-line, end-of-input and field read transactions
// into the record assembler and checks every result against a cycle-free
// model of record building, trimming, continuation checks and field reads.
// ----------------------------------------------------------------------------
module testbench;
  import clra_pkg::*;

  localparam int RECORD_DEPTH = RECORD_DEPTH_DEF;
  localparam int LINE_MAX     = LINE_MAX_DEF;
  localparam int FIELD_MAX    = FIELD_MAX_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [BYTE_W-1:0] char_t;
  typedef logic [FPOS_W-1:0] fpos_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [STATUS_W-1:0]      status;
    logic signed [TYPE_W-1:0] rtype;
    logic [RLEN_W-1:0]        rlen;
    char_t                    fchar;
    logic                     last;
  } out_item_t;

  typedef enum int {
    FAULT_NONE, FAULT_MARK, FAULT_HEAD, FAULT_LONG, FAULT_PEEK, FAULT_STOP
  } fault_e;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic [OPCODE_W-1:0]      opcode_i      = OP_BYTE;
  char_t                    line_byte_i   = '0;
  fpos_t                    field_start_i = '0;
  fpos_t                    field_end_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic [KIND_W-1:0]        kind_o;
  logic [STATUS_W-1:0]      status_o;
  logic signed [TYPE_W-1:0] record_type_o;
  logic [RLEN_W-1:0]        record_length_o;
  char_t                    field_char_o;
  logic                     last_o;

  // run control
  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;
  int stall_left;
  int cycle_count;
  int fail_count;
  int item_count;
  int records_done;

  // model of the assembler state
  char_t       rec_mem [RECORD_DEPTH];
  int          rec_len;
  int          line_pos;
  int          line_trim;
  logic [15:0] line_head;
  char_t       line_mark;
  char_t       line_flag;
  bit          rec_idle = 1'b1;
  out_item_t   due_outputs[$];

  continued_line_record_assembler DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .line_byte_i     (line_byte_i),
    .field_start_i   (field_start_i),
    .field_end_i     (field_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .status_o        (status_o),
    .record_type_o   (record_type_o),
    .record_length_o (record_length_o),
    .field_char_o    (field_char_o),
    .last_o          (last_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[continued_line_record_assembler] ERROR");
      $finish;
    end
  end

  // output side back-pressure in short random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------

  function automatic bit is_digit(input char_t c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void push_result(input logic [KIND_W-1:0] kind,
                                      input logic [STATUS_W-1:0] status,
                                      input logic [TYPE_W-1:0] rtype,
                                      input logic [RLEN_W-1:0] rlen,
                                      input char_t fchar, input logic last);
    out_item_t r;
    r.kind   = kind;
    r.status = status;
    r.rtype  = rtype;
    r.rlen   = rlen;
    r.fchar  = fchar;
    r.last   = last;
    due_outputs.push_back(r);
  endfunction

  function automatic void clear_line();
    line_pos  = 0;
    line_trim = 0;
    line_head = '0;
    line_mark = '0;
    line_flag = '0;
  endfunction

  function automatic void open_record();
    if (rec_idle) begin
      rec_len  = 0;
      rec_idle = 1'b0;
      clear_line();
    end
  endfunction

  // close the record and report it; any error empties it first
  function automatic void close_record(input logic [STATUS_W-1:0] st);
    char_t a, b;
    int    t;
    if (st != ST_OK) rec_len = 0;
    rec_idle = 1'b1;
    clear_line();
    t = 0;
    if (rec_len >= 2) begin
      a = rec_mem[0];
      b = rec_mem[1];
      if (a == CH_SPACE || (a >= CH_TAB && a <= CH_CR) || a == CH_PLUS)
        t = is_digit(b) ? int'(b) - int'(CH_ZERO) : 0;
      else if (a == CH_MINUS)
        t = is_digit(b) ? int'(CH_ZERO) - int'(b) : 0;
      else if (is_digit(a))
        t = is_digit(b) ? (int'(a) - int'(CH_ZERO)) * 10 + int'(b) - int'(CH_ZERO)
                        : int'(a) - int'(CH_ZERO);
    end
    records_done++;
    push_result(KIND_REC, st, t[TYPE_W-1:0], rec_len[RLEN_W-1:0], '0, 1'b1);
  endfunction

  // advance the model by one accepted transaction
  function automatic void assembler_step(input logic [OPCODE_W-1:0] op, input char_t ch,
                                         input fpos_t fs, input fpos_t fe);
    int pos, skip, total, span, n, fs_i, fe_i;
    bit past_end;
    case (op)
      OP_BYTE: begin
        open_record();
        pos = line_pos;
        if (pos < LINE_MAX) begin
          if (pos == 0) line_head = {ch, 8'h00};
          else if (pos == 1) line_head[7:0] = ch;
          // track last two non-space characters for the flag and end mark
          if (ch != CH_SPACE) begin
            line_flag = (line_trim == pos) ? line_mark : CH_SPACE;
            line_mark = ch;
            line_trim = pos + 1;
          end
          skip = (rec_len == 0) ? 0 : 2;
          if (pos >= skip && rec_len + pos - skip < RECORD_DEPTH)
            rec_mem[rec_len + pos - skip] = ch;
        end
        if (pos <= LINE_MAX) line_pos = pos + 1;
      end
      OP_EOL: begin
        open_record();
        if (line_pos > LINE_MAX) begin
          close_record(ST_LONG);
        end else if (line_trim < 2 || line_mark != CH_PCT) begin
          close_record(ST_MISS);
        end else if (rec_len != 0 && (line_head != PREFIX_CONT || line_trim < 4)) begin
          close_record(ST_BADC);
        end else begin
          total = rec_len + line_trim - ((rec_len == 0) ? 2 : 4);
          if (total > RECORD_DEPTH) begin
            close_record(ST_OVF);
          end else begin
            rec_len = total;
            if (line_flag != CH_ONE) close_record(ST_OK);
            else clear_line();
          end
        end
      end
      OP_EOI: begin
        if (!rec_idle) close_record(ST_EOI);
      end
      default: begin
        fs_i = fs;
        fe_i = fe;
        if (rec_len == 0 || fe_i < fs_i) begin
          push_result(KIND_EMPTY, ST_OK, '0, '0, '0, 1'b1);
        end else begin
          span     = fe_i - fs_i + 1;
          past_end = (fs_i == 0) || (fs_i + span > rec_len + 1);
          n        = (span < FIELD_MAX) ? span : FIELD_MAX;
          for (int i = 0; i < n; i++)
            push_result(KIND_CHAR, ST_OK, '0, '0,
                        past_end ? CH_SPACE : rec_mem[fs_i - 1 + i], i == n - 1);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [10:0] want,
                                      input logic [10:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // outputs are stable from the falling edge up to the accepting rising edge
  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (due_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0h", $time, kind_o);
        fail_count++;
      end else begin
        want = due_outputs.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("status", want.status, status_o);
        check_field("record_type", want.rtype, record_type_o);
        check_field("record_length", want.rlen, record_length_o);
        check_field("field_char", want.fchar, field_char_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic fpos_t rand_pos();
    return fpos_t'($urandom_range(0, 2047));
  endfunction

  function automatic char_t pick_char();
    case ($urandom_range(0, 3))
      0:       return char_t'($urandom_range(CH_ZERO, CH_NINE));
      1:       return CH_SPACE;
      default: return char_t'($urandom_range(0, 255));
    endcase
  endfunction

  // one input transaction, with an occasional gap before it
  task automatic send_item(input logic [OPCODE_W-1:0] op, input char_t ch,
                           input fpos_t fs, input fpos_t fe);
    bit took;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    line_byte_i   <= ch;
    field_start_i <= fs;
    field_end_i   <= fe;
    do begin
      @(negedge clk_i);
      took = (in_ready_o === 1'b1);
      @(posedge clk_i);
    end while (!took);
    if (!((op == OP_EOI && rec_idle) ||
          (op == OP_BYTE && !rec_idle && line_pos >= LINE_MAX)))
      item_count++;
    assembler_step(op, ch, fs, fe);
  endtask

  task automatic send_char(input char_t ch);
    send_item(OP_BYTE, ch, rand_pos(), rand_pos());
  endtask

  task automatic send_eol();
    send_item(OP_EOL, pick_char(), rand_pos(), rand_pos());
  endtask

  task automatic send_eoi();
    send_item(OP_EOI, pick_char(), rand_pos(), rand_pos());
  endtask

  task automatic read_field(input int fs, input int fe);
    send_item(OP_FIELD, pick_char(), fpos_t'(fs), fpos_t'(fe));
  endtask

  task automatic send_text(input string s, input bit with_eol);
    for (int i = 0; i < s.len(); i++) send_char(char_t'(s[i]));
    if (with_eol) send_eol();
  endtask

  task automatic read_field_random();
    int fs, fe;
    case ($urandom_range(0, 5))
      0: begin
        fs = rand_pos();
        fe = rand_pos();
      end
      1: begin
        fs = $urandom_range(1024, 2047);
        fe = $urandom_range(1024, 2047);
      end
      default: begin
        fs = $urandom_range(0, rec_len + 2);
        fe = fs + int'($urandom_range(0, 70)) - 1;
        if (fe < 0) fe = 0;
      end
    endcase
    read_field(fs, fe);
  endtask

  // one line: optional head, optional field read, random data, flag, end mark, trailing spaces, end of line
  task automatic send_line(input bit with_head, input logic [15:0] head, input int n_data,
                           input char_t flag, input char_t mark, input int pad,
                           input bit peek);
    if (with_head) begin
      send_char(head[15:8]);
      send_char(head[7:0]);
    end
    if (peek) read_field_random();
    repeat (n_data) send_char(pick_char());
    send_char(flag);
    send_char(mark);
    repeat (pad) send_char(CH_SPACE);
    send_eol();
  endtask

  // mostly well-formed record of one to four lines, sometimes broken
  task automatic random_record();
    int          n_lines, n_data;
    bit          last_line;
    char_t       flag, mark;
    logic [15:0] head;
    fault_e      fault;
    n_lines = $urandom_range(1, 4);
    for (int l = 0; l < n_lines; l++) begin
      last_line = (l == n_lines - 1);
      flag = ($urandom_range(0, 1) == 0) ? CH_ZERO : char_t'($urandom_range(0, 255));
      if (flag == CH_ONE || !last_line) flag = last_line ? CH_ZERO : CH_ONE;
      n_data = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      mark   = CH_PCT;
      head   = PREFIX_CONT;
      fault  = ($urandom_range(0, 7) == 0) ? fault_e'($urandom_range(FAULT_MARK, FAULT_STOP))
                                           : FAULT_NONE;
      case (fault)
        FAULT_MARK: begin
          mark = char_t'($urandom_range(0, 255));
          if (mark == CH_PCT) mark = CH_SPACE;
        end
        FAULT_HEAD: head = 16'($urandom);
        FAULT_LONG: n_data = $urandom_range(158, 200);
        FAULT_STOP: begin
          repeat ($urandom_range(0, 5)) send_char(pick_char());
          send_eoi();
          return;
        end
        default: ;
      endcase
      send_line(l > 0, head, n_data, flag, mark, $urandom_range(0, 2), fault == FAULT_PEEK);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // behaviour straight out of reset with nothing assembled
  task automatic test_idle_block();
    read_field(1, 4);
    send_eoi();
    send_eol();
    read_field(1024, 1024);
  endtask

  // record type decoding, continuation, empty first line, zero byte
  task automatic test_record_types();
    send_text("12HELLO1%  ", 1);
    send_text("00WORLD0%", 1);
    read_field(1, 12);
    send_text(" 5x0%", 1);
    send_text("-7Q0%", 1);
    send_text("+3Z0%", 1);
    send_text("\t40%", 1);
    send_text("7x0%", 1);
    send_text("-x0%", 1);
    send_text("ab0%", 1);
    send_text("70%", 1);
    // a first line giving no data leaves the next line as a first line
    send_text("1%", 1);
    send_text("42X0%", 1);
    // zero byte is an ordinary character
    send_char(CH_NINE);
    send_char(8'h00);
    send_text("0%", 1);
    read_field(1, 2);
  endtask

  // every error status but overflow, each leaving an empty record behind
  task automatic test_record_errors();
    send_text("12AB0X", 1);
    send_text("%", 1);
    send_text("12A1%", 1);
    send_text("01B0%", 1);
    send_text("12A1%", 1);
    send_text("00%", 1);
    read_field(1, 2);
    send_text("12AB1%", 1);
    send_text("00CD", 0);
    send_eoi();
    send_text("12", 0);
    send_eoi();
    // line of exactly the maximum length, then one over with a trailing space
    send_line(1'b0, '0, LINE_MAX - 2, CH_ZERO, CH_PCT, 0, 1'b0);
    send_line(1'b0, '0, LINE_MAX - 2, CH_ZERO, CH_PCT, 1, 1'b0);
    send_line(1'b0, '0, LINE_MAX + 8, CH_ZERO, CH_PCT, 0, 1'b0);
    read_field(1, 4);
  endtask

  // field bounds, capping, spaces past the end and reads of an open record
  task automatic test_field_reads();
    send_line(1'b0, '0, 98, CH_ZERO, CH_PCT, 0, 1'b0);
    read_field(1, 10);
    read_field(0, 5);
    read_field(0, 0);
    read_field(90, 98);
    read_field(90, 99);
    read_field(98, 98);
    read_field(5, 4);
    read_field(2047, 0);
    read_field(1, 64);
    read_field(1, 65);
    read_field(1, 98);
    read_field(1, 2047);
    read_field(1024, 1024);
    // record still open
    send_text("12AB1%", 1);
    read_field(1, 4);
    read_field(2, 5);
    send_text("00C", 0);
    read_field(1, 4);
    send_eoi();
  endtask

  // record filling the store exactly, then one character too many
  task automatic test_store_limits();
    for (int extra = 0; extra < 2; extra++) begin
      send_line(1'b0, '0, 160, CH_ONE, CH_PCT, 0, 1'b0);
      repeat (5) send_line(1'b1, PREFIX_CONT, 158, CH_ONE, CH_PCT, 0, 1'b0);
      send_line(1'b1, PREFIX_CONT, 74 + extra, CH_ZERO, CH_PCT, 0, 1'b0);
      read_field(961, 1024);
      read_field(1, 64);
      read_field(1000, 1025);
      read_field(1024, 1024);
      read_field(1025, 1025);
    end
  endtask

  // random records, field reads and stray transactions
  task automatic test_random_mix();
    int item_goal, record_goal;
    item_goal   = item_count + 500;
    record_goal = records_done + 40;
    while (item_count < item_goal || records_done < record_goal) begin
      if ($urandom_range(0, 5) == 0)
        send_item(OPCODE_W'($urandom), char_t'($urandom), rand_pos(), rand_pos());
      random_record();
      repeat ($urandom_range(0, 3)) read_field_random();
    end
    send_eoi();
  endtask

  // back-to-back traffic with no gaps on either side
  task automatic test_steady_stream();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    repeat (8) begin
      random_record();
      repeat ($urandom_range(1, 2)) read_field_random();
    end
    send_eoi();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_block();
    test_record_types();
    test_record_errors();
    test_field_reads();
    test_store_limits();
    test_random_mix();
    test_steady_stream();
    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[continued_line_record_assembler] OK");
    end else begin
      $display("[continued_line_record_assembler] ERROR");
    end
    $finish;
  end

endmodule
